>>> rtl/tick_timer_bank_defines.svh
// Assertion macros shared by the checker.
`ifndef TICK_TIMER_BANK_DEFINES_SVH
`define TICK_TIMER_BANK_DEFINES_SVH
`define TTB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TTB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/ttb_pkg.sv
package ttb_pkg;
  localparam int NumTimers = 8;
  localparam int SignalWidth = 16;
  localparam int IdxW = $clog2(NumTimers);

  localparam logic [3:0] OP_TICK = 4'd0;
  localparam logic [3:0] OP_ENABLE = 4'd1;
  localparam logic [3:0] OP_DISABLE = 4'd2;
  localparam logic [3:0] OP_ONESHOT = 4'd3;
  localparam logic [3:0] OP_OVF_READ = 4'd4;
  localparam logic [3:0] OP_REMAINING = 4'd5;
  localparam logic [3:0] OP_SET_RELOAD = 4'd6;
  localparam logic [3:0] OP_SET_SIGNAL = 4'd7;
  localparam logic [3:0] OP_SET_ERROR = 4'd8;

  localparam logic [2:0] KIND_DONE = 3'd0;
  localparam logic [2:0] KIND_SEND = 3'd1;
  localparam logic [2:0] KIND_FATAL = 3'd2;
  localparam logic [2:0] KIND_TICK_FATAL = 3'd3;
  localparam logic [2:0] KIND_ANSWER = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  timer_index;
    logic [15:0] tick_value;
    logic [7:0]  target_task;
    logic [15:0] signal_bits;
    logic [7:0]  error_value;
    logic [7:0]  pending_mask;
    logic [7:0]  tick_backlog;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  fired_timer;
    logic [7:0]  send_task;
    logic [15:0] send_signals;
    logic [7:0]  fatal_code;
    logic [15:0] answer;
    logic [31:0] tick_count;
    logic        last;
  } out_item_t;
endpackage

>>> rtl/tick_timer_bank.sv
// Channel | Valid    | Stall     | Payload
// input   | in_valid | in_stall  | in_item  (in_item_t)
// output  | out_valid| out_stall | out_item (out_item_t)
// A tick scans the timers one per cycle, while the output is free, with one
// shared compare/add unit: it is accepted in S_IDLE, decoded in S_OP,
// scanned in S_SCAN and closed in S_FLUSH. Other ops are accepted in S_IDLE
// and executed in S_OP. Each result waits in the output register; the
// scan pauses while a result is still held there (out_stall back-pressure).
// Reset is synchronous and clears all timer state, the count and the halt.
// Once halted after a fatal result, inputs are accepted and dropped.
module tick_timer_bank
  import ttb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_OP    = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  in_item_t cur;
  logic [31:0] ticks;
  logic halted;
  logic [IdxW-1:0] idx;
  // A firing result is parked here until the scan knows whether another
  // firing follows, so that last lands on the final beat of the tick.
  logic held_valid;
  out_item_t held_item;
  logic [NumTimers-1:0] en, ovf;
  logic [15:0] expiry [NumTimers];
  logic [15:0] reload [NumTimers];
  logic [7:0] err [NumTimers];
  logic [7:0] task_id [NumTimers];
  logic [SignalWidth-1:0] sigs [NumTimers];

  // Shared unit: selected timer, one 16-bit add and one compare.
  logic [IdxW-1:0] sel;
  logic [15:0] sum_a, sum_b, sum;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign sel = (state == S_SCAN) ? idx : cur.timer_index;
  assign sum = sum_a + sum_b;

  always_comb begin
    sum_a = expiry[sel];
    sum_b = reload[sel];
    if (state == S_OP) begin
      sum_a = ticks[15:0];
      if (cur.op == OP_ONESHOT) sum_b = cur.tick_value;
      if (cur.op == OP_REMAINING) sum_b = 16'(~expiry[sel] + 16'd1);
    end
  end

  function automatic out_item_t mk(logic [2:0] k, logic [2:0] t, logic [7:0] tk,
                                   logic [15:0] s, logic [7:0] c, logic [15:0] a,
                                   logic [31:0] cnt, logic l);
    out_item_t r;
    r.kind = k; r.fired_timer = t; r.send_task = tk; r.send_signals = s;
    r.fatal_code = c; r.answer = a; r.tick_count = cnt; r.last = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    logic [15:0] rel;
    state_t state_next;
    logic out_valid_next;
    out_item_t out_item_next;
    out_item_t fire_item;
    rel = 16'd0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    out_item_next = out_item;
    fire_item = '0;
    if (rst) begin
      state <= S_IDLE; ticks <= '0; halted <= 1'b0; out_valid <= 1'b0;
      en <= '0; ovf <= '0; idx <= '0; held_valid <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        expiry[i] <= '0; reload[i] <= '0; err[i] <= '0;
        task_id[i] <= '0; sigs[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !halted) begin
            cur <= in_item;
            state_next = S_OP;
            idx <= '0;
            held_valid <= 1'b0;
          end
        end
        S_OP: begin
          if (out_free) begin
            state_next = S_IDLE;
            out_valid_next = 1'b1;
            out_item_next = mk(KIND_DONE, (cur.op == OP_TICK) ? 3'd0 : cur.timer_index,
                               8'd0, 16'd0, 8'd0, 16'd0, ticks, 1'b1);
            if (cur.op == OP_TICK) begin
              if (cur.tick_backlog > 8'd1) begin
                out_item_next.kind = KIND_TICK_FATAL;
                halted <= 1'b1;
              end else if (cur.tick_backlog == 8'd1) begin
                ticks <= ticks + 32'd1;
                out_valid_next = 1'b0;
                state_next = S_SCAN;
              end
            end else begin
              case (cur.op)
                OP_ENABLE, OP_ONESHOT: begin
                  rel = (cur.op == OP_ONESHOT) ? cur.tick_value : reload[sel];
                  if (rel != 16'd0) begin
                    expiry[sel] <= sum;
                    en[sel] <= 1'b1;
                  end else begin
                    en[sel] <= 1'b0;
                    if (err[sel] != 8'd0) begin
                      out_item_next = mk(KIND_FATAL, cur.timer_index, 8'd0, 16'd0,
                                         err[sel], 16'd0, ticks, 1'b1);
                      halted <= 1'b1;
                    end else begin
                      if (cur.pending_mask[sel]) ovf[sel] <= 1'b1;
                      out_item_next = mk(KIND_SEND, cur.timer_index, task_id[sel],
                                         16'(sigs[sel]), 8'd0, 16'd0, ticks, 1'b1);
                    end
                  end
                  if (cur.op == OP_ONESHOT) reload[sel] <= 16'd0;
                end
                OP_DISABLE: en[sel] <= 1'b0;
                OP_OVF_READ: begin
                  out_item_next.kind = KIND_ANSWER;
                  out_item_next.answer = {15'd0, ovf[sel]};
                  ovf[sel] <= 1'b0;
                end
                OP_REMAINING: begin
                  out_item_next.kind = KIND_ANSWER;
                  // sum is ticks - expiry; remaining is its negation.
                  out_item_next.answer = en[sel] ? 16'(~sum + 16'd1) : 16'd0;
                end
                OP_SET_RELOAD: reload[sel] <= cur.tick_value;
                OP_SET_SIGNAL: begin
                  err[sel] <= 8'd0;
                  task_id[sel] <= cur.target_task;
                  sigs[sel] <= cur.signal_bits[SignalWidth-1:0];
                end
                OP_SET_ERROR: err[sel] <= cur.error_value;
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (en[sel] && expiry[sel] == ticks[15:0]) begin
              if (reload[sel] != 16'd0) expiry[sel] <= sum;
              else en[sel] <= 1'b0;
              if (err[sel] != 8'd0) begin
                // A fatal firing ends the scan; later timers are not examined.
                fire_item = mk(KIND_FATAL, sel, 8'd0, 16'd0, err[sel], 16'd0,
                               ticks, 1'b1);
                halted <= 1'b1;
                state_next = S_FLUSH;
              end else begin
                if (cur.pending_mask[sel]) ovf[sel] <= 1'b1;
                fire_item = mk(KIND_SEND, sel, task_id[sel], 16'(sigs[sel]), 8'd0,
                               16'd0, ticks, 1'b0);
              end
              // The parked firing is now known not to be the final beat.
              if (held_valid) begin
                out_valid_next = 1'b1;
                out_item_next = held_item;
              end
              held_valid <= 1'b1;
              held_item <= fire_item;
            end
            if (idx == IdxW'(NumTimers - 1)) state_next = S_FLUSH;
            idx <= idx + IdxW'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid_next = 1'b1;
            state_next = S_IDLE;
            if (held_valid) begin
              out_item_next = held_item;
              out_item_next.last = 1'b1;
            end else begin
              out_item_next = mk(KIND_DONE, 3'd0, 8'd0, 16'd0, 8'd0, 16'd0, ticks, 1'b1);
            end
            held_valid <= 1'b0;
          end
        end
        default: state_next = S_IDLE;
      endcase
      state <= state_next;
      out_valid <= out_valid_next;
      out_item <= out_item_next;
    end
  end
endmodule

>>> rtl/ttb_checker.sv
`include "tick_timer_bank_defines.svh"
module ttb_checker
  import ttb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);
  `TTB_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `TTB_ASSERT_IMP(a_kind, clk, rst, out_valid, out_item.kind <= KIND_ANSWER)
  `TTB_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_item))
  `TTB_ASSERT_IMP(a_send, clk, rst, out_valid && out_item.kind != KIND_SEND,
                  out_item.send_signals == 16'd0)
  `TTB_ASSERT_IMP(a_fatal_last, clk, rst,
                  out_valid && (out_item.kind == KIND_FATAL || out_item.kind == KIND_TICK_FATAL),
                  out_item.last)
endmodule

bind tick_timer_bank ttb_checker u_ttb_checker (.*);
